[rtl/csp_pkg.sv]
// Shared types, character codes and keyword helpers for the control statement parser.
package csp_pkg;

  typedef enum logic [10:0] {
    PH_AT1    = 11'h001,
    PH_AT2    = 11'h002,
    PH_KEY    = 11'h004,
    PH_CMSKIP = 11'h008,
    PH_CMTEXT = 11'h010,
    PH_TERM   = 11'h020,
    PH_XSKIP  = 11'h040,
    PH_XOPT   = 11'h080,
    PH_XWSKIP = 11'h100,
    PH_XWORD  = 11'h200,
    PH_DONE   = 11'h400
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOTFND = 2'd1,
    ST_SYNTAX = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CMD_NONE = 3'd0,
    CMD_CM   = 3'd1,
    CMD_MSG  = 3'd2,
    CMD_TERM = 3'd3,
    CMD_X    = 3'd4
  } cmd_e;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_T     = 8'h54;

  localparam logic [31:0] KW_CM   = 32'h0000_434D;
  localparam logic [31:0] KW_MSG  = 32'h004D_5347;
  localparam logic [31:0] KW_TERM = 32'h5445_524D;
  localparam logic [31:0] KW_X    = 32'h0000_0058;

  localparam logic [2:0] KW_MAX_LEN = 3'd4;

  localparam logic [4:0] OPT_C         = 5'h01;
  localparam logic [4:0] OPT_I         = 5'h02;
  localparam logic [4:0] OPT_O         = 5'h04;
  localparam logic [4:0] OPT_R         = 5'h08;
  localparam logic [4:0] OPT_T         = 5'h10;
  localparam logic [4:0] OPT_X_DEFAULT = 5'h17;

  typedef struct packed {
    logic       text_valid;
    logic [7:0] text_char;
    logic [6:0] text_pos;
    logic       done_res;
    status_e    status;
    cmd_e       command;
    logic [4:0] option_bits;
    logic [7:0] text_length;
    logic       text_truncated;
  } result_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) ? c - 8'd32 : c;
  endfunction

  function automatic cmd_e match_keyword(input logic [31:0] kw, input logic [2:0] len,
                                         input logic ovf);
    cmd_e m;
    m = CMD_NONE;
    if (!ovf) begin
      if (len == 3'd2 && kw == KW_CM) m = CMD_CM;
      else if (len == 3'd3 && kw == KW_MSG) m = CMD_MSG;
      else if (len == 3'd4 && kw == KW_TERM) m = CMD_TERM;
      else if (len == 3'd1 && kw == KW_X) m = CMD_X;
    end
    return m;
  endfunction

endpackage

[rtl/csp_core.sv]
// Statement parse state and the per-character step logic.
module csp_core #(
  parameter int TEXT_MAX = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       char_i,
  input  logic             last_i,
  output csp_pkg::result_t res_o,
  output logic             has_res_o
);
  import csp_pkg::*;

  localparam int CntW = $clog2(TEXT_MAX + 1);

  phase_e          phase_q, phase_d;
  logic [31:0]     kw_q, kw_d;
  logic [2:0]      kw_len_q, kw_len_d;
  logic            kw_ovf_q, kw_ovf_d;
  cmd_e            cmd_q, cmd_d;
  logic [4:0]      opt_q, opt_d;
  status_e         status_q, status_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] nonsp_q, nonsp_d;
  logic            ovf_q, ovf_d;

  always_comb begin
    logic [7:0] up;
    logic       letter;
    logic       take;
    cmd_e       m;
    status_e    st_fin;
    cmd_e       cmd_fin;
    logic [4:0] opt_fin;

    up       = upcase(char_i);
    letter   = (up >= CH_UP_A) && (up <= CH_UP_Z);
    take     = 1'b0;
    m        = CMD_NONE;
    phase_d  = phase_q;
    kw_d     = kw_q;
    kw_len_d = kw_len_q;
    kw_ovf_d = kw_ovf_q;
    cmd_d    = cmd_q;
    opt_d    = opt_q;
    status_d = status_q;
    cnt_d    = cnt_q;
    nonsp_d  = nonsp_q;
    ovf_d    = ovf_q;
    res_o    = '0;

    unique case (phase_q)
      PH_AT1: begin
        if (char_i == CH_AT) phase_d = PH_AT2;
        else begin
          status_d = ST_NOTFND;
          phase_d  = PH_DONE;
        end
      end
      PH_AT2: begin
        if (char_i == CH_AT) phase_d = PH_KEY;
        else begin
          status_d = ST_NOTFND;
          phase_d  = PH_DONE;
        end
      end
      PH_KEY: begin
        if (letter) begin
          if (kw_len_q < KW_MAX_LEN) begin
            kw_d     = {kw_q[23:0], up};
            kw_len_d = kw_len_q + 3'd1;
          end else begin
            kw_ovf_d = 1'b1;
          end
        end else if (char_i == CH_SPACE || char_i == CH_COMMA) begin
          m = match_keyword(kw_q, kw_len_q, kw_ovf_q);
          if (kw_len_q == 3'd0 || m == CMD_NONE) begin
            status_d = ST_SYNTAX;
            phase_d  = PH_DONE;
          end else begin
            cmd_d = m;
            if (char_i == CH_COMMA) begin
              status_d = ST_SYNTAX;
              phase_d  = PH_DONE;
            end else if (m == CMD_CM || m == CMD_MSG) phase_d = PH_CMSKIP;
            else if (m == CMD_TERM) phase_d = PH_TERM;
            else phase_d = PH_XSKIP;
          end
        end else begin
          status_d = ST_SYNTAX;
          phase_d  = PH_DONE;
        end
      end
      PH_CMSKIP: begin
        if (char_i != CH_SPACE) begin
          phase_d = PH_CMTEXT;
          take    = 1'b1;
        end
      end
      PH_CMTEXT: take = 1'b1;
      PH_TERM: begin
        if (char_i != CH_SPACE) begin
          status_d = ST_SYNTAX;
          phase_d  = PH_DONE;
        end
      end
      PH_XSKIP, PH_XOPT: begin
        // skip leading spaces only before the first option letter
        if (phase_q == PH_XOPT || char_i != CH_SPACE) begin
          case (up)
            CH_COMMA: phase_d = PH_XWSKIP;
            CH_C: begin opt_d = opt_q | OPT_C; phase_d = PH_XOPT; end
            CH_I: begin opt_d = opt_q | OPT_I; phase_d = PH_XOPT; end
            CH_O: begin opt_d = opt_q | OPT_O; phase_d = PH_XOPT; end
            CH_R: begin opt_d = opt_q | OPT_R; phase_d = PH_XOPT; end
            CH_T: begin opt_d = opt_q | OPT_T; phase_d = PH_XOPT; end
            default: begin
              status_d = ST_SYNTAX;
              phase_d  = PH_DONE;
            end
          endcase
        end
      end
      PH_XWSKIP: begin
        if (char_i != CH_SPACE) begin
          phase_d = PH_XWORD;
          take    = 1'b1;
        end
      end
      PH_XWORD: begin
        if (char_i == CH_SPACE) phase_d = PH_DONE;
        else take = 1'b1;
      end
      default: ;
    endcase

    if (take) begin
      if (cnt_q < CntW'(TEXT_MAX)) begin
        res_o.text_valid = 1'b1;
        res_o.text_char  = char_i;
        res_o.text_pos   = 7'(cnt_q);
        cnt_d            = cnt_q + 1'b1;
        if (char_i != CH_SPACE) nonsp_d = cnt_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end

    if (last_i) begin
      st_fin  = status_d;
      cmd_fin = cmd_d;
      opt_fin = opt_d;
      if (phase_d == PH_AT2) begin
        st_fin = ST_NOTFND;
      end else if (phase_d == PH_KEY) begin
        m = match_keyword(kw_d, kw_len_d, kw_ovf_d);
        if (kw_len_d == 3'd0 || m == CMD_NONE) st_fin = ST_SYNTAX;
        else cmd_fin = m;
      end
      if (st_fin == ST_OK && cmd_fin == CMD_X && opt_fin == 5'd0) opt_fin = OPT_X_DEFAULT;

      res_o.done_res       = 1'b1;
      res_o.status         = st_fin;
      res_o.command        = cmd_fin;
      res_o.option_bits    = opt_fin;
      res_o.text_truncated = ovf_d;
      if (cmd_fin == CMD_CM || cmd_fin == CMD_MSG) res_o.text_length = 8'(nonsp_d);
      else if (cmd_fin == CMD_X) res_o.text_length = 8'(cnt_d);

      // start the next statement clean
      phase_d  = PH_AT1;
      kw_d     = '0;
      kw_len_d = '0;
      kw_ovf_d = 1'b0;
      cmd_d    = CMD_NONE;
      opt_d    = '0;
      status_d = ST_OK;
      cnt_d    = '0;
      nonsp_d  = '0;
      ovf_d    = 1'b0;
    end

    has_res_o = res_o.text_valid | res_o.done_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_AT1;
      kw_q     <= '0;
      kw_len_q <= '0;
      kw_ovf_q <= 1'b0;
      cmd_q    <= CMD_NONE;
      opt_q    <= '0;
      status_q <= ST_OK;
      cnt_q    <= '0;
      nonsp_q  <= '0;
      ovf_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      kw_q     <= kw_d;
      kw_len_q <= kw_len_d;
      kw_ovf_q <= kw_ovf_d;
      cmd_q    <= cmd_d;
      opt_q    <= opt_d;
      status_q <= status_d;
      cnt_q    <= cnt_d;
      nonsp_q  <= nonsp_d;
      ovf_q    <= ovf_d;
    end
  end

`ifndef SYNTHESIS
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_i) |=> (phase_q == PH_AT1 && cnt_q == '0 && status_q == ST_OK))
    else $error("parser state not cleared after statement end");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TEXT_MAX))
    else $error("text count beyond limit");
  a_nonsp_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nonsp_q <= cnt_q)
    else $error("nonspace length exceeds text count");
`endif

endmodule

[rtl/control_statement_parser_top.sv]
// Top level of the control statement parser: parse core and output register pair.
// Parses one control statement character per cycle: an item is taken every clock
// while the output side keeps up, and each character's result (a text character,
// the final status on the last character, or both) is held in the output registers.
// Results pass through a main output register backed by a skid register,
// so input stalls only when both hold a result that has not been taken. Text past
// TEXT_MAX characters is dropped and reported through text_truncated_o.
module control_statement_parser_top #(
  parameter int TEXT_MAX = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       text_valid_o,
  output logic [7:0] text_char_o,
  output logic [6:0] text_pos_o,
  output logic       done_res_o,
  output logic [1:0] status_o,
  output logic [2:0] command_o,
  output logic [4:0] option_bits_o,
  output logic [7:0] text_length_o,
  output logic       text_truncated_o
);
  import csp_pkg::*;

  logic    accept;
  logic    push;
  logic    pop;
  logic    has_res;
  result_t res;
  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign push       = accept && has_res;
  assign pop        = out_valid_q && !out_stall_i;

  csp_core #(
    .TEXT_MAX(TEXT_MAX)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (char_in_i),
    .last_i   (last_char_i),
    .res_o    (res),
    .has_res_o(has_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) skid_valid_q <= 1'b0;
    end else if (push) begin
      if (out_valid_q && !pop) skid_valid_q <= 1'b1;
      else out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      // hold the new result aside when the output register is still stalled
      if (out_valid_q && !pop) skid_q <= res;
      else out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign text_valid_o     = out_q.text_valid;
  assign text_char_o      = out_q.text_char;
  assign text_pos_o       = out_q.text_pos;
  assign done_res_o       = out_q.done_res;
  assign status_o         = out_q.status;
  assign command_o        = out_q.command;
  assign option_bits_o    = out_q.option_bits;
  assign text_length_o    = out_q.text_length;
  assign text_truncated_o = out_q.text_truncated;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");
  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !done_res_o) |-> text_valid_o)
    else $error("result carries neither text nor status");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> (status_o != 2'd3 && command_o <= CMD_X))
    else $error("final status or command out of range");
`endif

endmodule

[bench/tb_control_statement_parser_top.sv]
// Self-checking testbench for control_statement_parser_top: random statements, scoreboard.
module tb_control_statement_parser_top;
  timeunit 1ns;
  timeprecision 1ps;
  import csp_pkg::*;

  localparam int TEXT_LIMIT   = 128;
  localparam int PHASE_ITEMS  = 190;
  localparam int DRAIN_CYCLES = 8;

  // Tracks the parse of the current statement and queues the results it should produce.
  class statement_tracker;
    phase_e      phase;
    logic [31:0] kw;
    logic [2:0]  kw_len;
    bit          kw_ovf;
    cmd_e        cmd;
    logic [4:0]  opts;
    status_e     st;
    int unsigned text_cnt;
    int unsigned nonspace_len;
    bit          text_ovf;
    result_t     outcomes[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned statements;
    int unsigned truncations;
    int unsigned by_status[3];

    function new();
      clear();
    endfunction

    function void clear();
      phase        = PH_AT1;
      kw           = '0;
      kw_len       = '0;
      kw_ovf       = 1'b0;
      cmd          = CMD_NONE;
      opts         = '0;
      st           = ST_OK;
      text_cnt     = 0;
      nonspace_len = 0;
      text_ovf     = 1'b0;
    endfunction

    function logic [7:0] fold_case(logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    function bit is_alpha(logic [7:0] c);
      logic [7:0] u;
      u = fold_case(c);
      return u >= 8'h41 && u <= 8'h5A;
    endfunction

    function cmd_e lookup_command();
      if (kw_ovf) return CMD_NONE;
      if (kw_len == 3'd2 && kw == 32'h0000_434D) return CMD_CM;
      if (kw_len == 3'd3 && kw == 32'h004D_5347) return CMD_MSG;
      if (kw_len == 3'd4 && kw == 32'h5445_524D) return CMD_TERM;
      if (kw_len == 3'd1 && kw == 32'h0000_0058) return CMD_X;
      return CMD_NONE;
    endfunction

    function void abort(status_e s);
      st    = s;
      phase = PH_DONE;
    endfunction

    function void record_text(logic [7:0] c, inout result_t r);
      if (text_cnt < TEXT_LIMIT) begin
        r.text_valid = 1'b1;
        r.text_char  = c;
        r.text_pos   = text_cnt[6:0];
        text_cnt++;
        if (c != CH_SPACE) nonspace_len = text_cnt;
      end else begin
        text_ovf = 1'b1;
      end
    endfunction

    function void apply_option(logic [7:0] c);
      case (fold_case(c))
        CH_COMMA: phase = PH_XWSKIP;
        CH_C: begin opts |= OPT_C; phase = PH_XOPT; end
        CH_I: begin opts |= OPT_I; phase = PH_XOPT; end
        CH_O: begin opts |= OPT_O; phase = PH_XOPT; end
        CH_R: begin opts |= OPT_R; phase = PH_XOPT; end
        CH_T: begin opts |= OPT_T; phase = PH_XOPT; end
        default: abort(ST_SYNTAX);
      endcase
    endfunction

    // Advance the parse by one accepted character; return 0 if the character was ignored.
    function bit note_char(logic [7:0] c, bit is_last);
      result_t r;
      bit      active;
      cmd_e    found;
      r      = '0;
      active = (phase != PH_DONE);
      case (phase)
        PH_AT1: if (c == CH_AT) phase = PH_AT2; else abort(ST_NOTFND);
        PH_AT2: if (c == CH_AT) phase = PH_KEY; else abort(ST_NOTFND);
        PH_KEY: begin
          if (is_alpha(c)) begin
            if (kw_len < 3'd4) begin
              kw = {kw[23:0], fold_case(c)};
              kw_len++;
            end else begin
              kw_ovf = 1'b1;
            end
          end else if (c == CH_SPACE || c == CH_COMMA) begin
            found = lookup_command();
            if (found == CMD_NONE) begin
              abort(ST_SYNTAX);
            end else begin
              // a comma right after a good keyword still reports the command
              cmd = found;
              if (c == CH_COMMA) abort(ST_SYNTAX);
              else if (found == CMD_CM || found == CMD_MSG) phase = PH_CMSKIP;
              else if (found == CMD_TERM) phase = PH_TERM;
              else phase = PH_XSKIP;
            end
          end else begin
            abort(ST_SYNTAX);
          end
        end
        PH_CMSKIP: begin
          if (c != CH_SPACE) begin
            phase = PH_CMTEXT;
            record_text(c, r);
          end
        end
        PH_CMTEXT: record_text(c, r);
        PH_TERM: if (c != CH_SPACE) abort(ST_SYNTAX);
        PH_XSKIP: if (c != CH_SPACE) apply_option(c);
        PH_XOPT: apply_option(c);
        PH_XWSKIP: begin
          if (c != CH_SPACE) begin
            phase = PH_XWORD;
            record_text(c, r);
          end
        end
        PH_XWORD: if (c == CH_SPACE) phase = PH_DONE; else record_text(c, r);
        default: ;
      endcase

      if (is_last) begin
        if (phase == PH_AT2) begin
          st = ST_NOTFND;
        end else if (phase == PH_KEY) begin
          found = lookup_command();
          if (found == CMD_NONE) st = ST_SYNTAX;
          else cmd = found;
        end
        if (st == ST_OK && cmd == CMD_X && opts == '0) opts = OPT_C | OPT_I | OPT_O | OPT_T;
        r.done_res       = 1'b1;
        r.status         = st;
        r.command        = cmd;
        r.option_bits    = opts;
        r.text_truncated = text_ovf;
        if (cmd == CMD_CM || cmd == CMD_MSG) r.text_length = nonspace_len[7:0];
        else if (cmd == CMD_X) r.text_length = text_cnt[7:0];
        statements++;
        by_status[st]++;
        if (text_ovf) truncations++;
        clear();
      end
      if (r.text_valid || r.done_res) outcomes.push_back(r);
      return active;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_outcome(result_t got);
      result_t want;
      if (outcomes.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %p", $time, got);
        mismatches++;
        return;
      end
      want = outcomes.pop_front();
      checked++;
      compare_field("text_valid", want.text_valid, got.text_valid);
      compare_field("text_char", want.text_char, got.text_char);
      compare_field("text_pos", want.text_pos, got.text_pos);
      compare_field("done_res", want.done_res, got.done_res);
      compare_field("status", want.status, got.status);
      compare_field("command", want.command, got.command);
      compare_field("option_bits", want.option_bits, got.option_bits);
      compare_field("text_length", want.text_length, got.text_length);
      compare_field("text_truncated", want.text_truncated, got.text_truncated);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_in = '0;
  logic       last_char = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       text_valid;
  logic [7:0] text_char;
  logic [6:0] text_pos;
  logic       done_res;
  logic [1:0] status;
  logic [2:0] command;
  logic [4:0] option_bits;
  logic [7:0] text_length;
  logic       text_truncated;

  statement_tracker book = new();
  int unsigned      idle_pct;
  int unsigned      stall_pct;
  int unsigned      active_items;
  int unsigned      sent_items;
  logic [7:0]       stmt[$];

  control_statement_parser_top #(
    .TEXT_MAX(TEXT_LIMIT)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .char_in_i       (char_in),
    .last_char_i     (last_char),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .text_valid_o    (text_valid),
    .text_char_o     (text_char),
    .text_pos_o      (text_pos),
    .done_res_o      (done_res),
    .status_o        (status),
    .command_o       (command),
    .option_bits_o   (option_bits),
    .text_length_o   (text_length),
    .text_truncated_o(text_truncated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      book.check_outcome(result_t'({text_valid, text_char, text_pos, done_res, status,
                                   command, option_bits, text_length, text_truncated}));
    end
  end

  initial begin
    #1_000_000;
    $display("tb_control_statement_parser_top failed");
    $finish;
  end

  function automatic logic [7:0] any_case(logic [7:0] c);
    if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) && $urandom_range(1))
      return c ^ 8'h20;
    return c;
  endfunction

  function automatic void add_text(string t, bit vary_case);
    foreach (t[i]) stmt.push_back(vary_case ? any_case(t[i]) : t[i]);
  endfunction

  function automatic void add_spaces(int n);
    repeat (n) stmt.push_back(CH_SPACE);
  endfunction

  function automatic logic [7:0] text_byte(bit no_space);
    int unsigned roll;
    logic [7:0]  c;
    roll = $urandom_range(99);
    if (roll < 15) c = CH_SPACE;
    else if (roll < 85) c = 8'($urandom_range(33, 126));
    else c = 8'($urandom_range(0, 255));
    if (no_space && c == CH_SPACE) c = 8'h2E;
    return c;
  endfunction

  function automatic void add_tail(int n, bit no_space);
    repeat (n) stmt.push_back(text_byte(no_space));
  endfunction

  function automatic void build_random(bit long_text);
    string       keywords[4] = '{"CM", "MSG", "TERM", "X"};
    string       letters = "CIORT";
    int unsigned k;
    int unsigned roll;
    stmt.delete();
    roll = $urandom_range(99);
    if (roll < 80 || long_text) begin
      k = $urandom_range(3);
      if (long_text && k == 2) k = 0;
      add_text("@@", 1'b0);
      add_text(keywords[k], 1'b1);
      if (!long_text && $urandom_range(9) == 0) return;
      stmt.push_back(CH_SPACE);
      case (k)
        0, 1: begin
          add_spaces($urandom_range(3));
          add_tail(long_text ? $urandom_range(120, 150) : $urandom_range(16), 1'b0);
          add_spaces($urandom_range(3));
        end
        2: begin
          add_spaces($urandom_range(4));
          if ($urandom_range(3) == 0) add_tail($urandom_range(1, 4), 1'b1);
        end
        default: begin
          add_spaces($urandom_range(2));
          repeat ($urandom_range(4)) begin
            if ($urandom_range(9) == 0)
              stmt.push_back($urandom_range(1) ? CH_SPACE : 8'($urandom_range(255)));
            else
              stmt.push_back(any_case(letters[$urandom_range(4)]));
          end
          if (long_text || $urandom_range(2) > 0) begin
            stmt.push_back(CH_COMMA);
            add_spaces($urandom_range(2));
            add_tail(long_text ? $urandom_range(120, 150) : $urandom_range(10), 1'b1);
            if ($urandom_range(1)) begin
              stmt.push_back(CH_SPACE);
              add_tail($urandom_range(4), 1'b0);
            end
          end
        end
      endcase
    end else begin
      case ($urandom_range(5))
        0: add_tail($urandom_range(1, 8), 1'b0);
        1: begin
          stmt.push_back(CH_AT);
          add_tail($urandom_range(3), 1'b0);
        end
        2: begin
          add_text("@@", 1'b0);
          repeat ($urandom_range(5, 7)) stmt.push_back(any_case(8'($urandom_range(65, 90))));
          stmt.push_back(CH_SPACE);
          add_tail($urandom_range(4), 1'b0);
        end
        3: begin
          add_text("@@", 1'b0);
          add_text(keywords[$urandom_range(3)], 1'b1);
          stmt.push_back(CH_COMMA);
          add_tail($urandom_range(4), 1'b0);
        end
        4: begin
          add_text("@@", 1'b0);
          repeat ($urandom_range(1, 4)) stmt.push_back(any_case(8'($urandom_range(65, 90))));
          case ($urandom_range(3))
            0: stmt.push_back(CH_SPACE);
            1: stmt.push_back(CH_COMMA);
            2: stmt.push_back(8'($urandom_range(255)));
            default: ;
          endcase
          add_tail($urandom_range(3), 1'b0);
        end
        default: begin
          add_text("@@", 1'b0);
          add_tail($urandom_range(1, 4), 1'b0);
        end
      endcase
    end
  endfunction

  // Entered and left at a falling edge; one nonblocking update of valid per step.
  task automatic send_char(logic [7:0] c, bit is_last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_in   <= c;
    last_char <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    if (book.note_char(c, is_last)) active_items++;
    @(negedge clk);
  endtask

  task automatic send_statement();
    foreach (stmt[i]) send_char(stmt[i], i == stmt.size() - 1);
  endtask

  task automatic send_directed(string t);
    stmt.delete();
    add_text(t, 1'b0);
    send_statement();
  endtask

  initial begin
    int unsigned idle_set[4]  = '{0, 76, 0, 6};
    int unsigned stall_set[4] = '{0, 0, 76, 6};
    int unsigned stmt_idx;
    idle_pct  = 0;
    stall_pct = 0;
    stmt_idx  = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // short statements: lone '@', bad first byte, empty keyword, bare X, comma after keyword
    send_directed("@");
    send_directed("\377");
    send_directed("\000");
    send_directed("@@");
    send_directed("@@x");
    send_directed("@@Cm,");
    send_directed("@@TERM ");
    send_directed("@@X i,");

    for (int p = 0; p < 4; p++) begin
      idle_pct     = idle_set[p];
      stall_pct    = stall_set[p];
      active_items = 0;
      while (active_items < PHASE_ITEMS) begin
        build_random(stmt_idx % 25 == 7);
        send_statement();
        stmt_idx++;
      end
    end

    in_valid <= 1'b0;
    while (book.outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d statements (%0d characters) under four idle/stall mixes.",
             book.statements, sent_items);
    $display("Checked %0d results: %0d ok, %0d not found, %0d syntax, %0d truncated.",
             book.checked, book.by_status[ST_OK], book.by_status[ST_NOTFND],
             book.by_status[ST_SYNTAX], book.truncations);
    if (book.mismatches == 0) begin
      $display("tb_control_statement_parser_top passed");
    end else begin
      $display("tb_control_statement_parser_top failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/csp_pkg.sv
rtl/csp_core.sv
rtl/control_statement_parser_top.sv
bench/tb_control_statement_parser_top.sv
